// ----- rtl/core/sphere_triangle_chord_accumulator_assert.svh -----
// assertion macros for the sphere triangle chord accumulator
// used by the top level only, no other dependencies
`ifndef SPHERE_TRIANGLE_CHORD_ACCUMULATOR_ASSERT_SVH
`define SPHERE_TRIANGLE_CHORD_ACCUMULATOR_ASSERT_SVH

// same-cycle implication
`define STCA_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("stca assertion failed");

// next-cycle implication
`define STCA_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("stca assertion failed");

`endif

// ----- rtl/core/stca_pkg.sv -----
// shared constants and types for the sphere triangle chord accumulator
// no dependencies
`default_nettype none
package stca_pkg;
   localparam int BISECT_STEPS = 10;
   localparam int FRAC_BITS    = 16;
   localparam int COORD_W      = 32;
   localparam int RADIUS_W     = 31;
   localparam int CHORD_W      = 32;
   localparam int SUM_W        = 48;
   localparam int CAT_W        = 2;
   localparam int COEF_SHIFT   = BISECT_STEPS + 1;
   localparam int COEF_W       = BISECT_STEPS + 2;
   localparam int ITER_W       = $clog2(BISECT_STEPS + 1);
   localparam int DIFF_W       = COORD_W + 1;
   localparam int MUL_W        = DIFF_W + 1;
   localparam int PROD_W       = 2 * MUL_W;
   localparam int ACC_W        = 2 * DIFF_W;
   localparam int ROOT_W       = ACC_W / 2;
   localparam int SQ_CNT_W     = $clog2(ROOT_W + 1);
   localparam int NCOORD       = 9;

   localparam logic [RADIUS_W-1:0] RADIUS_RESET = RADIUS_W'(64'd1 << FRAC_BITS);

   typedef logic signed [COORD_W-1:0] coord_type;

   typedef struct packed {
      logic                            operation;
      logic                            last_face;
      logic [NCOORD-1:0][COORD_W-1:0]  coords;
   } req_item_type;

   typedef struct packed {
      logic [CAT_W-1:0]   category;
      logic [CHORD_W-1:0] chord;
      logic [SUM_W-1:0]   sum;
      logic               final_flag;
   } rsp_item_type;
endpackage
`default_nettype wire

// ----- rtl/core/stca_mul.sv -----
// shared signed multiplier with registered product
// depends on stca_pkg
`default_nettype none
module stca_mul (
   input  wire logic                                clock,
   input  wire logic signed [stca_pkg::MUL_W-1:0]  op_a,
   input  wire logic signed [stca_pkg::MUL_W-1:0]  op_b,
   output logic signed [stca_pkg::PROD_W-1:0]      prod_ff
);
   always_ff @(posedge clock) begin
      prod_ff <= op_a * op_b;
   end
endmodule
`default_nettype wire

// ----- rtl/core/stca_sqrt.sv -----
// iterative restoring integer square root, two radicand bits a cycle
// depends on stca_pkg
`default_nettype none
module stca_sqrt (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [stca_pkg::ACC_W-1:0]  value,
   output logic                             done_ff,
   output logic [stca_pkg::ROOT_W-1:0]      root_ff
);
   localparam int RW = stca_pkg::ROOT_W;

   logic [stca_pkg::ACC_W-1:0]    rad_ff;
   logic [RW:0]                   rem_ff;
   logic [stca_pkg::SQ_CNT_W-1:0] cnt_ff;
   logic                          run_ff;
   logic [RW+2:0]                 rem_sh;
   logic [RW+2:0]                 trial;
   logic                          ge;

   always_comb begin
      rem_sh = {rem_ff, rad_ff[stca_pkg::ACC_W-1 -: 2]};
      trial  = {1'b0, root_ff, 2'b01};
      ge     = rem_sh >= trial;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff <= 1'b1;
            cnt_ff <= '0;
         end else if (run_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == stca_pkg::SQ_CNT_W'(RW - 1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rad_ff  <= value;
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (run_ff) begin
         rad_ff  <= {rad_ff[stca_pkg::ACC_W-3:0], 2'b00};
         if (ge) begin
            rem_ff  <= (RW+1)'(rem_sh - trial);
            root_ff <= {root_ff[RW-2:0], 1'b1};
         end else begin
            rem_ff  <= rem_sh[RW:0];
            root_ff <= {root_ff[RW-2:0], 1'b0};
         end
      end
   end
endmodule
`default_nettype wire

// ----- rtl/core/stca_core.sv -----
// sequencer and datapath: inside test, bisection along each cut edge, chord and sum
// depends on stca_pkg, stca_mul, stca_sqrt
`default_nettype none
module stca_core (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   input  wire stca_pkg::req_item_type          item,
   input  wire logic [stca_pkg::RADIUS_W-1:0]   radius,
   output logic                                 ready,
   output logic                                 res_valid,
   input  wire logic                            res_take,
   output stca_pkg::rsp_item_type               res
);
   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_R2   = 4'd1;
   localparam logic [3:0] S_VSQ  = 4'd2;
   localparam logic [3:0] S_VCMP = 4'd3;
   localparam logic [3:0] S_SET  = 4'd4;
   localparam logic [3:0] S_PT   = 4'd5;
   localparam logic [3:0] S_PSQ  = 4'd6;
   localparam logic [3:0] S_PCMP = 4'd7;
   localparam logic [3:0] S_EDGE = 4'd8;
   localparam logic [3:0] S_CSQ  = 4'd9;
   localparam logic [3:0] S_SQS  = 4'd10;
   localparam logic [3:0] S_SQW  = 4'd11;
   localparam logic [3:0] S_DONE = 4'd12;

   localparam int CW = stca_pkg::COORD_W;
   localparam int DW = stca_pkg::DIFF_W;
   localparam int MW = stca_pkg::MUL_W;
   localparam int KW = stca_pkg::COEF_W;

   logic [3:0]                      state_ff;
   logic                            phase_ff;
   logic [1:0]                      ax_ff, vi_ff, solo_ff;
   logic [1:0]                      cnt_ff;
   logic [stca_pkg::ITER_W-1:0]     iter_ff;
   logic                            edge_ff, final_ff, found_ff;
   logic [KW-1:0]                   k_ff, step_ff;
   logic [2:0]                      inside_ff;
   logic [stca_pkg::ACC_W-1:0]      acc_ff, r2_ff;
   stca_pkg::coord_type             v_ff [3][3];
   stca_pkg::coord_type             q_ff [3];
   stca_pkg::coord_type             p_ff [3];
   stca_pkg::coord_type             p1_ff [3];
   logic [stca_pkg::SUM_W-1:0]      sum_ff;
   logic [stca_pkg::CHORD_W-1:0]    chord_ff;
   logic [stca_pkg::CAT_W-1:0]      cat_ff;
   logic                            fin_ff;

   logic signed [MW-1:0]            op_a, op_b;
   logic signed [stca_pkg::PROD_W-1:0] prod_ff, prod_sh;
   stca_pkg::coord_type             d_lhs, d_rhs;
   logic signed [DW-1:0]            diff;
   logic [1:0]                      o_sel, in_sel, out_sel;
   logic [1:0]                      cnt_new, solo_new;
   logic                            want;
   logic                            sq_start, sq_done;
   logic [stca_pkg::ROOT_W-1:0]     sq_root;
   logic [stca_pkg::SUM_W:0]        sum_add;
   logic [stca_pkg::CHORD_W-1:0]    chord_sat;

   // edge end points
   always_comb begin
      o_sel = edge_ff ? ((solo_ff == 2'd2) ? 2'd1 : 2'd2) : ((solo_ff == 2'd0) ? 2'd1 : 2'd0);
      if (cnt_ff == 2'd1) begin
         in_sel  = solo_ff;
         out_sel = o_sel;
      end else begin
         in_sel  = o_sel;
         out_sel = solo_ff;
      end
   end

   // operand selection for the shared multiplier
   always_comb begin
      case (state_ff)
         S_VSQ: begin
            d_lhs = v_ff[vi_ff][ax_ff];
            d_rhs = q_ff[ax_ff];
         end
         S_PT: begin
            d_lhs = v_ff[out_sel][ax_ff];
            d_rhs = v_ff[in_sel][ax_ff];
         end
         S_PSQ: begin
            d_lhs = p_ff[ax_ff];
            d_rhs = q_ff[ax_ff];
         end
         S_CSQ: begin
            d_lhs = p1_ff[ax_ff];
            d_rhs = p_ff[ax_ff];
         end
         default: begin
            d_lhs = '0;
            d_rhs = '0;
         end
      endcase
      diff = DW'(d_lhs) - DW'(d_rhs);
      if (state_ff == S_R2) begin
         op_a = MW'({1'b0, radius});
         op_b = MW'({1'b0, radius});
      end else if (state_ff == S_PT) begin
         op_a = MW'(diff);
         op_b = MW'({1'b0, k_ff});
      end else begin
         op_a = MW'(diff);
         op_b = MW'(diff);
      end
      prod_sh = prod_ff >>> stca_pkg::COEF_SHIFT;
   end

   // vertex count, odd-one-out vertex, saturated chord and sum
   always_comb begin
      cnt_new  = 2'(inside_ff[0]) + 2'(inside_ff[1]) + 2'(inside_ff[2]);
      want     = cnt_new == 2'd1;
      if (inside_ff[0] == want) solo_new = 2'd0;
      else if (inside_ff[1] == want) solo_new = 2'd1;
      else solo_new = 2'd2;
      chord_sat = (sq_root[stca_pkg::ROOT_W-1:stca_pkg::CHORD_W] != '0) ? '1 :
                  sq_root[stca_pkg::CHORD_W-1:0];
      sum_add   = {1'b0, sum_ff} + (stca_pkg::SUM_W+1)'(chord_sat);
   end

   assign sq_start  = state_ff == S_SQS;
   assign ready     = state_ff == S_IDLE;
   assign res_valid = state_ff == S_DONE;
   assign res.category   = cat_ff;
   assign res.chord      = chord_ff;
   assign res.sum        = sum_ff;
   assign res.final_flag = fin_ff;

   stca_mul u_mul (
      .clock   (clock),
      .op_a    (op_a),
      .op_b    (op_b),
      .prod_ff (prod_ff)
   );

   stca_sqrt u_sqrt (
      .clock   (clock),
      .reset   (reset),
      .start   (sq_start),
      .value   (acc_ff),
      .done_ff (sq_done),
      .root_ff (sq_root)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         phase_ff <= 1'b0;
         sum_ff   <= '0;
         for (int i = 0; i < 3; i++) q_ff[i] <= '0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (start) begin
                  fin_ff   <= item.operation & item.last_face;
                  chord_ff <= '0;
                  cat_ff   <= '0;
                  phase_ff <= 1'b0;
                  if (!item.operation) begin
                     for (int i = 0; i < 3; i++) q_ff[i] <= item.coords[i];
                     sum_ff   <= '0;
                     state_ff <= S_DONE;
                  end else begin
                     for (int i = 0; i < 3; i++)
                        for (int j = 0; j < 3; j++) v_ff[i][j] <= item.coords[3*i+j];
                     state_ff <= S_R2;
                  end
               end
            end
            S_R2: begin
               phase_ff <= ~phase_ff;
               if (phase_ff) begin
                  r2_ff    <= prod_ff[stca_pkg::ACC_W-1:0];
                  acc_ff   <= '0;
                  vi_ff    <= 2'd0;
                  ax_ff    <= 2'd0;
                  state_ff <= S_VSQ;
               end
            end
            S_VSQ, S_PSQ, S_CSQ: begin
               phase_ff <= ~phase_ff;
               if (phase_ff) begin
                  acc_ff <= acc_ff + prod_ff[stca_pkg::ACC_W-1:0];
                  if (ax_ff == 2'd2) begin
                     ax_ff <= 2'd0;
                     case (state_ff)
                        S_VSQ:   state_ff <= S_VCMP;
                        S_PSQ:   state_ff <= S_PCMP;
                        default: state_ff <= S_SQS;
                     endcase
                  end else begin
                     ax_ff <= ax_ff + 2'd1;
                  end
               end
            end
            S_VCMP: begin
               inside_ff[vi_ff] <= acc_ff <= r2_ff;
               acc_ff <= '0;
               if (vi_ff == 2'd2) state_ff <= S_SET;
               else begin
                  vi_ff    <= vi_ff + 2'd1;
                  state_ff <= S_VSQ;
               end
            end
            S_SET: begin
               cnt_ff  <= cnt_new;
               solo_ff <= solo_new;
               cat_ff  <= cnt_new;
               edge_ff <= 1'b0;
               final_ff <= 1'b0;
               found_ff <= 1'b0;
               iter_ff <= '0;
               k_ff    <= KW'(1) << stca_pkg::BISECT_STEPS;
               step_ff <= KW'(1) << (stca_pkg::BISECT_STEPS - 1);
               ax_ff   <= 2'd0;
               acc_ff  <= '0;
               if (cnt_new == 2'd1 || cnt_new == 2'd2) state_ff <= S_PT;
               else state_ff <= S_DONE;
            end
            S_PT: begin
               phase_ff <= ~phase_ff;
               if (phase_ff) begin
                  p_ff[ax_ff] <= v_ff[in_sel][ax_ff] + prod_sh[CW-1:0];
                  if (ax_ff == 2'd2) begin
                     ax_ff    <= 2'd0;
                     state_ff <= final_ff ? S_EDGE : S_PSQ;
                  end else begin
                     ax_ff <= ax_ff + 2'd1;
                  end
               end
            end
            S_PCMP: begin
               if (!found_ff) begin
                  if (acc_ff < r2_ff) k_ff <= k_ff + step_ff;
                  else if (acc_ff > r2_ff) k_ff <= k_ff - step_ff;
                  else found_ff <= 1'b1;
               end
               step_ff <= step_ff >> 1;
               acc_ff  <= '0;
               if (iter_ff == stca_pkg::ITER_W'(stca_pkg::BISECT_STEPS - 1)) final_ff <= 1'b1;
               else iter_ff <= iter_ff + 1'b1;
               state_ff <= S_PT;
            end
            S_EDGE: begin
               acc_ff <= '0;
               if (!edge_ff) begin
                  for (int i = 0; i < 3; i++) p1_ff[i] <= p_ff[i];
                  edge_ff  <= 1'b1;
                  final_ff <= 1'b0;
                  found_ff <= 1'b0;
                  iter_ff  <= '0;
                  k_ff     <= KW'(1) << stca_pkg::BISECT_STEPS;
                  step_ff  <= KW'(1) << (stca_pkg::BISECT_STEPS - 1);
                  state_ff <= S_PT;
               end else begin
                  state_ff <= S_CSQ;
               end
            end
            S_SQS: state_ff <= S_SQW;
            S_SQW: begin
               if (sq_done) begin
                  chord_ff <= chord_sat;
                  sum_ff   <= sum_add[stca_pkg::SUM_W] ? '1 : sum_add[stca_pkg::SUM_W-1:0];
                  state_ff <= S_DONE;
               end
            end
            S_DONE: begin
               if (res_take) state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

// ----- rtl/core/sphere_triangle_chord_accumulator.sv -----
// top level: stream ports, radius register, result register
// depends on stca_pkg, stca_core and the assertion macro header
//
// usage
//   req channel carries one item per transfer: tuser is the operation
//   (0 = new query point, 1 = face), tlast marks the final face of a point.
//   a point item stores the query point and clears the running sum.
//   rsp channel returns one result per item: tuser is the category (number
//   of vertices within the radius), tdata the chord and the running sum,
//   tlast echoes the final-face mark of a face item.
//   csr_we/csr_wdata write the radius (Q15.16), only while the block is idle: a user rule, not enforced.
// work per item
//   a point item goes straight to its result; a face first runs the inside test
//   (9 products on the one multiplier, plus a compare per vertex); with 0 or 3
//   vertices inside that is all; with 1 or 2 inside it runs BISECT_STEPS bisection
//   steps on each cut edge, then the chord distance and the bit-pair square root unit.
//   one item is in work at a time; req_tready is high only while idle.
// reset and stalls
//   reset sets the radius to 1.0, clears query point and sum, drops rsp_tvalid.
//   a result waits in the output register while rsp_tready is low; the next
//   item is taken meanwhile and its result is held in the core until then.
`default_nettype none
`include "sphere_triangle_chord_accumulator_assert.svh"
module sphere_triangle_chord_accumulator (
   input  wire logic          clock,
   input  wire logic          reset,
   // input channel
   input  wire logic          req_tvalid,
   output logic               req_tready,
   input  wire logic [287:0]  req_tdata,   // first_x, first_y, first_z, second_x..z, third_x..z
   input  wire logic          req_tuser,   // operation
   input  wire logic          req_tlast,   // last_face
   // result channel
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   output logic [79:0]        rsp_tdata,   // chord_length, circumference_sum
   output logic [1:0]         rsp_tuser,   // category
   output logic               rsp_tlast,   // sum_final
   // radius register
   input  wire logic          csr_we,
   input  wire logic [30:0]   csr_wdata
);
   logic [stca_pkg::RADIUS_W-1:0] radius_ff;
   logic                          rsp_valid_ff;
   stca_pkg::rsp_item_type        rsp_ff;
   stca_pkg::req_item_type        item;
   stca_pkg::rsp_item_type        core_res;
   logic                          core_ready, core_valid, take;

   // unpack the request transfer
   always_comb begin
      item.operation = req_tuser;
      item.last_face = req_tlast;
      for (int i = 0; i < stca_pkg::NCOORD; i++)
         item.coords[i] = req_tdata[stca_pkg::COORD_W*i +: stca_pkg::COORD_W];
   end

   assign req_tready = core_ready;
   // core result moves on when the output register is empty or being drained
   assign take       = core_valid && (!rsp_valid_ff || rsp_tready);

   stca_core u_core (
      .clock     (clock),
      .reset     (reset),
      .start     (req_tvalid && core_ready),
      .item      (item),
      .radius    (radius_ff),
      .ready     (core_ready),
      .res_valid (core_valid),
      .res_take  (take),
      .res       (core_res)
   );

   // radius register
   always_ff @(posedge clock) begin
      if (reset) radius_ff <= stca_pkg::RADIUS_RESET;
      else if (csr_we) radius_ff <= csr_wdata;
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (take) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take) rsp_ff <= core_res;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_ff.sum, rsp_ff.chord};
   assign rsp_tuser  = rsp_ff.category;
   assign rsp_tlast  = rsp_ff.final_flag;

   // an accepted item keeps the block busy
   `STCA_ASSERT_NXT(a_busy_after_transfer, clock, reset, req_tvalid && req_tready, !req_tready)
   // no chord unless the face is cut
   `STCA_ASSERT_IMP(a_chord_zero, clock, reset, rsp_tvalid && (rsp_tuser == 2'd0 || rsp_tuser == 2'd3), rsp_tdata[31:0] == 32'd0)
   // the running sum always covers the chord just added
   `STCA_ASSERT_IMP(a_sum_covers, clock, reset, rsp_tvalid, rsp_tdata[79:32] >= {16'd0, rsp_tdata[31:0]})
endmodule
`default_nettype wire
